### hw/rtl/chord_voicing_arranger_macros.svh
// ----------------------------------------------------------------------------
// Chord voicing arranger assertion macros
// Assertion helpers used by the arranger controller; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef CHORD_VOICING_ARRANGER_MACROS_SVH
`define CHORD_VOICING_ARRANGER_MACROS_SVH
`ifndef SYNTHESIS
`define CVA_ASSERT_SAME(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");
`define CVA_ASSERT_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define CVA_ASSERT_SAME(name, trig, cond)
`define CVA_ASSERT_NEXT(name, trig, cond)
`endif
`endif

### hw/rtl/cva_pkg.sv
// ----------------------------------------------------------------------------
// Chord voicing arranger package
// Types, codes and constant tables shared by the arranger modules.
// ----------------------------------------------------------------------------
`default_nettype none
package cva_pkg;
  typedef logic signed [9:0] note_t;

  localparam note_t OCTAVE = 10'sd12;
  localparam note_t TOP_NOTE = 10'sd127;

  localparam logic [1:0] STYLE_ROOTLESS = 2'd1;
  localparam logic [1:0] STYLE_OPEN = 2'd2;

  localparam logic [2:0] SHAPE_SUS4 = 3'd2;
  localparam logic [2:0] SHAPE_SEVENTH = 3'd3;

  localparam logic [2:0] REG_VOICING_STYLE = 3'd0;
  localparam logic [2:0] REG_OMIT_FIFTH = 3'd1;
  localparam logic [2:0] REG_INVERSION_COUNT = 3'd2;
  localparam logic [2:0] REG_LEGACY_SEVENTH = 3'd3;
  localparam logic [2:0] REG_DENSE_FLOOR = 3'd4;
  localparam logic [2:0] REG_ROOTLESS_FLOOR = 3'd5;
  localparam logic [2:0] REG_CEILING_NOTE = 3'd6;

  localparam logic [2:0] ORDER_PLAIN [7] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6};
  localparam logic [2:0] ORDER_THIRTEENTH [7] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};

  typedef struct packed {
    logic load;
    logic open;
    logic inv_step;
    logic sort_step;
    logic shift_up;
    logic shift_down;
    logic restore;
    logic out_load;
  } cva_cmd_t;

  typedef struct packed {
    logic zero;
    logic inv_done;
    logic sort_done;
    logic can_up;
    logic can_up_top;
    logic can_down;
    logic fit_ok;
  } cva_status_t;
endpackage
`default_nettype wire

### hw/rtl/cva_chord_if.sv
// ----------------------------------------------------------------------------
// Chord request channel
// Valid/ready channel carrying one chord's candidate tones and flags.
// ----------------------------------------------------------------------------
`default_nettype none
interface cva_chord_if;
  logic       valid;
  logic       ready;
  logic [6:0] root_note;
  logic [6:0] third_note;
  logic [6:0] fifth_note;
  logic [6:0] seventh_note;
  logic [6:0] sixth_note;
  logic [6:0] ninth_note;
  logic [6:0] eleventh_note;
  logic [6:0] active_mask;
  logic       fifth_flag;
  logic [2:0] chord_shape;
  logic       with_thirteenth;

  modport source (output valid, root_note, third_note, fifth_note, seventh_note,
    sixth_note, ninth_note, eleventh_note, active_mask, fifth_flag, chord_shape,
    with_thirteenth, input ready);
  modport sink (input valid, root_note, third_note, fifth_note, seventh_note,
    sixth_note, ninth_note, eleventh_note, active_mask, fifth_flag, chord_shape,
    with_thirteenth, output ready);
endinterface
`default_nettype wire

### hw/rtl/cva_voiced_if.sv
// ----------------------------------------------------------------------------
// Voiced chord channel
// Valid/ready channel carrying one voiced chord and its tone count.
// ----------------------------------------------------------------------------
`default_nettype none
interface cva_voiced_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] voiced_0;
  logic signed [8:0] voiced_1;
  logic signed [8:0] voiced_2;
  logic signed [8:0] voiced_3;
  logic signed [8:0] voiced_4;
  logic signed [8:0] voiced_5;
  logic [2:0]        tone_count;

  modport source (output valid, voiced_0, voiced_1, voiced_2, voiced_3, voiced_4,
    voiced_5, tone_count, input ready);
  modport sink (input valid, voiced_0, voiced_1, voiced_2, voiced_3, voiced_4,
    voiced_5, tone_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/cva_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none
interface cva_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/cva_datapath.sv
// ----------------------------------------------------------------------------
// Chord voicing arranger datapath
// Configuration registers, tone gathering, voicing, inversion, sorting and octave fitting.
// ----------------------------------------------------------------------------
`default_nettype none
module cva_datapath import cva_pkg::*; #(
  parameter int MAX_TONES = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        root_note,
  input  logic [6:0]        third_note,
  input  logic [6:0]        fifth_note,
  input  logic [6:0]        seventh_note,
  input  logic [6:0]        sixth_note,
  input  logic [6:0]        ninth_note,
  input  logic [6:0]        eleventh_note,
  input  logic [6:0]        active_mask,
  input  logic              fifth_flag,
  input  logic [2:0]        chord_shape,
  input  logic              with_thirteenth,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  cva_cmd_t          cmd,
  output cva_status_t       status,
  output logic signed [8:0] voiced_0,
  output logic signed [8:0] voiced_1,
  output logic signed [8:0] voiced_2,
  output logic signed [8:0] voiced_3,
  output logic signed [8:0] voiced_4,
  output logic signed [8:0] voiced_5,
  output logic [2:0]        tone_count
);
  localparam int NS = (MAX_TONES > 6) ? MAX_TONES : 6;
  localparam int IW = $clog2(NS);
  localparam int PW = $clog2(NS + 1);

  logic [1:0] voicing_style;
  logic       omit_fifth;
  logic [2:0] inversion_count;
  logic       legacy_seventh;
  logic [6:0] dense_floor;
  logic [6:0] rootless_floor;
  logic [6:0] ceiling_note;

  logic [6:0] cand [7];
  logic [2:0] ord [7];
  logic [6:0] act;
  logic       triad_in;
  logic       rootless_in;
  logic [2:0] gcnt;
  note_t      gnotes [NS];

  note_t      notes [NS];
  note_t      compact [NS];
  note_t      sn [NS];
  logic [2:0] count;
  logic [6:0] c0, c1, c2, c3;
  logic       shape3;
  logic       triad;
  logic       rootless;
  logic [2:0] inv_cnt;
  logic [PW-1:0] pass_cnt;
  logic [IW-1:0] mi;
  logic [2:0] cm1;
  logic [2:0] cm2;
  logic [2:0] inv_tgt;
  logic [6:0] flr;
  note_t      flr_s;
  note_t      ceil_s;
  note_t      lo;
  note_t      hi;
  logic signed [8:0] vout [6];

  assign cand[0] = root_note;
  assign cand[1] = third_note;
  assign cand[2] = fifth_note;
  assign cand[3] = seventh_note;
  assign cand[4] = sixth_note;
  assign cand[5] = ninth_note;
  assign cand[6] = eleventh_note;

  always_ff @(posedge clk) begin
    if (rst) begin
      voicing_style <= '0;
      omit_fifth <= 1'b0;
      inversion_count <= '0;
      legacy_seventh <= 1'b0;
      dense_floor <= 7'd48;
      rootless_floor <= 7'd52;
      ceiling_note <= 7'd96;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VOICING_STYLE:   voicing_style <= cfg_data[1:0];
        REG_OMIT_FIFTH:      omit_fifth <= cfg_data[0];
        REG_INVERSION_COUNT: inversion_count <= cfg_data[2:0];
        REG_LEGACY_SEVENTH:  legacy_seventh <= cfg_data[0];
        REG_DENSE_FLOOR:     dense_floor <= cfg_data;
        REG_ROOTLESS_FLOOR:  rootless_floor <= cfg_data;
        REG_CEILING_NOTE:    ceiling_note <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    triad_in = (chord_shape <= SHAPE_SUS4);
    rootless_in = (voicing_style == STYLE_ROOTLESS) && (!triad_in || legacy_seventh);
    act = active_mask;
    if (rootless_in) act[0] = 1'b0;
    if (omit_fifth) act[2] = 1'b0;
    if (with_thirteenth) act[6] = 1'b0;
    if (($countones(act) > MAX_TONES) && act[2] && fifth_flag) act[2] = 1'b0;
    for (int k = 0; k < 7; k++) begin
      ord[k] = with_thirteenth ? ORDER_THIRTEENTH[k] : ORDER_PLAIN[k];
    end
    gcnt = '0;
    gnotes = '{default: '0};
    for (int k = 0; k < 7; k++) begin
      if (act[ord[k]] && (gcnt < 3'(MAX_TONES))) begin
        gnotes[gcnt[IW-1:0]] = note_t'({3'b000, cand[ord[k]]});
        gcnt = gcnt + 3'd1;
      end
    end
  end

  always_comb begin
    mi = '0;
    for (int i = 1; i < NS; i++) begin
      if ((i < int'(count)) && (notes[i] < notes[mi])) mi = IW'(i);
    end
  end

  always_comb begin
    sn = notes;
    for (int i = 0; i < NS - 1; i++) begin
      if ((i[0] == pass_cnt[0]) && (i + 1 < int'(count)) && (notes[i] > notes[i + 1])) begin
        sn[i] = notes[i + 1];
        sn[i + 1] = notes[i];
      end
    end
  end

  always_comb begin
    cm1 = count - 3'd1;
    cm2 = count - 3'd2;
    inv_tgt = (inversion_count > cm1) ? cm1 : inversion_count;
    flr = (count >= 3'd5) ? dense_floor : 7'd0;
    if (rootless && (rootless_floor > flr)) flr = rootless_floor;
    flr_s = note_t'({3'b000, flr});
    ceil_s = note_t'({3'b000, ceiling_note});
    lo = notes[0];
    hi = notes[cm1[IW-1:0]];
    status.zero = (count == 3'd0);
    status.inv_done = (inv_cnt >= inv_tgt);
    status.sort_done = (pass_cnt == PW'(NS));
    status.can_up = (lo < flr_s) && (hi + OCTAVE <= ceil_s);
    status.can_up_top = (lo < flr_s) && (hi + OCTAVE <= TOP_NOTE);
    status.can_down = (hi > ceil_s) && (lo - OCTAVE >= flr_s);
    status.fit_ok = (lo >= flr_s) && (hi <= ceil_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cnt <= '0;
      pass_cnt <= '0;
    end else if (cmd.load) begin
      inv_cnt <= '0;
      pass_cnt <= '0;
    end else if (cmd.inv_step) begin
      inv_cnt <= inv_cnt + 3'd1;
    end else if (cmd.sort_step) begin
      pass_cnt <= pass_cnt + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      notes <= gnotes;
      compact <= gnotes;
      count <= gcnt;
      c0 <= cand[0];
      c1 <= cand[1];
      c2 <= cand[2];
      c3 <= cand[3];
      shape3 <= (chord_shape == SHAPE_SEVENTH);
      triad <= triad_in;
      rootless <= rootless_in;
    end else if (cmd.open) begin
      if (voicing_style == STYLE_OPEN) begin
        if (legacy_seventh || (shape3 && (count == 3'd4))) begin
          notes[0] <= note_t'({3'b000, c0});
          notes[1] <= note_t'({3'b000, c2});
          notes[2] <= note_t'({3'b000, c3});
          notes[3] <= note_t'({3'b000, c1}) + OCTAVE;
        end else if ((count == 3'd3) && triad) begin
          notes[0] <= note_t'({3'b000, c0});
          notes[1] <= note_t'({3'b000, c2});
          notes[2] <= note_t'({3'b000, c1}) + OCTAVE;
        end else if (count >= 3'd4) begin
          notes[cm2[IW-1:0]] <= notes[cm2[IW-1:0]] - OCTAVE;
        end
      end
    end else if (cmd.inv_step) begin
      notes[mi] <= notes[mi] + OCTAVE;
    end else if (cmd.sort_step) begin
      notes <= sn;
    end else if (cmd.shift_up) begin
      for (int i = 0; i < NS; i++) notes[i] <= notes[i] + OCTAVE;
    end else if (cmd.shift_down) begin
      for (int i = 0; i < NS; i++) notes[i] <= notes[i] - OCTAVE;
    end else if (cmd.restore) begin
      notes <= compact;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int k = 0; k < 6; k++) vout[k] <= (k < int'(count)) ? notes[k][8:0] : 9'sd0;
      tone_count <= count;
    end
  end

  assign voiced_0 = vout[0];
  assign voiced_1 = vout[1];
  assign voiced_2 = vout[2];
  assign voiced_3 = vout[3];
  assign voiced_4 = vout[4];
  assign voiced_5 = vout[5];
endmodule
`default_nettype wire

### hw/rtl/cva_controller.sv
// ----------------------------------------------------------------------------
// Chord voicing arranger controller
// Sequences the datapath through gathering, voicing, inversion, sorting,
// octave fitting and the compact fallback, and owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chord_voicing_arranger_macros.svh"
module cva_controller import cva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  cva_status_t status,
  output cva_cmd_t    cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPEN  = 3'd1;
  localparam logic [2:0] S_INV   = 3'd2;
  localparam logic [2:0] S_SORT  = 3'd3;
  localparam logic [2:0] S_UP    = 3'd4;
  localparam logic [2:0] S_DOWN  = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       fb;

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_OPEN;
        end
      end
      S_OPEN: begin
        cmd.open = 1'b1;
        state_next = S_INV;
      end
      S_INV: begin
        if (status.zero) state_next = S_EMIT;
        else if (!status.inv_done) cmd.inv_step = 1'b1;
        else state_next = S_SORT;
      end
      S_SORT: begin
        if (!status.sort_done) cmd.sort_step = 1'b1;
        else state_next = S_UP;
      end
      S_UP: begin
        if (fb ? status.can_up_top : status.can_up) cmd.shift_up = 1'b1;
        else state_next = S_DOWN;
      end
      S_DOWN: begin
        if (status.can_down) cmd.shift_down = 1'b1;
        else state_next = fb ? S_EMIT : S_CHECK;
      end
      S_CHECK: begin
        if (status.fit_ok) begin
          state_next = S_EMIT;
        end else begin
          cmd.restore = 1'b1;
          state_next = S_UP;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fb <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) fb <= 1'b0;
      else if (cmd.restore) fb <= 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `CVA_ASSERT_SAME(a_ready_only_idle, in_ready, state == S_IDLE)
  `CVA_ASSERT_NEXT(a_accept_to_open, in_valid && in_ready, state == S_OPEN)
  `CVA_ASSERT_SAME(a_emit_when_free, cmd.out_load, !out_valid || out_ready)
  `CVA_ASSERT_NEXT(a_restore_once, cmd.restore, fb && state == S_UP)
endmodule
`default_nettype wire

### hw/rtl/chord_voicing_arranger.sv
// ----------------------------------------------------------------------------
// Chord voicing arranger
// Turns one chord's candidate tones into a voiced chord of up to six notes.
// ----------------------------------------------------------------------------
// One chord is handled at a time. Handling a chord takes these steps in order:
// gathering the tones, the open voicing, one inversion step after another, one
// sort pass after another over the note slots, and octave shifts while fitting
// the chord between the floor and the ceiling, with a second fitting round when
// the compact fallback is taken; with no tone active, the chord goes straight
// from the open voicing to the output. The octave shifter moves the chord by one
// octave per cycle. A finished result waits in an output register, and the next
// chord may be taken meanwhile.
`default_nettype none
module chord_voicing_arranger import cva_pkg::*; #(
  parameter int MAX_TONES = 6
) (
  input  logic    clk,
  input  logic    rst,
  cva_chord_if.sink    chord,
  cva_voiced_if.source voiced,
  cva_cfg_if.sink      cfg
);
  cva_cmd_t    cmd;
  cva_status_t status;

  assign cfg.ready = 1'b1;

  cva_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chord.valid),
    .in_ready  (chord.ready),
    .out_valid (voiced.valid),
    .out_ready (voiced.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cva_datapath #(.MAX_TONES(MAX_TONES)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .root_note       (chord.root_note),
    .third_note      (chord.third_note),
    .fifth_note      (chord.fifth_note),
    .seventh_note    (chord.seventh_note),
    .sixth_note      (chord.sixth_note),
    .ninth_note      (chord.ninth_note),
    .eleventh_note   (chord.eleventh_note),
    .active_mask     (chord.active_mask),
    .fifth_flag      (chord.fifth_flag),
    .chord_shape     (chord.chord_shape),
    .with_thirteenth (chord.with_thirteenth),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .cmd             (cmd),
    .status          (status),
    .voiced_0        (voiced.voiced_0),
    .voiced_1        (voiced.voiced_1),
    .voiced_2        (voiced.voiced_2),
    .voiced_3        (voiced.voiced_3),
    .voiced_4        (voiced.voiced_4),
    .voiced_5        (voiced.voiced_5),
    .tone_count      (voiced.tone_count)
  );
endmodule
`default_nettype wire
